FILE: design/grid_frequency_alert_classifier_top_defines.svh
// Assertion macros for the top-level file, which checks its own logic.
`ifndef GRID_FREQUENCY_ALERT_CLASSIFIER_TOP_DEFINES_SVH
`define GRID_FREQUENCY_ALERT_CLASSIFIER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define GFAC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define GFAC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define GFAC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define GFAC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

FILE: design/gfac_pkg.sv
`default_nettype none

package gfac_pkg;

   localparam int FREQ_WIDTH = 17;
   localparam int RAMP_WIDTH = 20;
   localparam int WARMUP_WIDTH = 8;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 20;
   // |df| * 1000 fits in 27 bits
   localparam int NUM_WIDTH = 27;
   localparam int DIV_STEPS = NUM_WIDTH;
   localparam int DIV_COUNT_WIDTH = $clog2(DIV_STEPS);
   localparam logic [DIV_COUNT_WIDTH-1:0] DIV_LAST = DIV_COUNT_WIDTH'(DIV_STEPS - 1);

   localparam logic [NUM_WIDTH-1:0] MS_PER_S = NUM_WIDTH'(1000);
   localparam logic [RAMP_WIDTH-1:0] RAMP_MAX = '1;

   localparam logic [FREQ_WIDTH-1:0] TARGET_RESET = FREQ_WIDTH'(50000);
   localparam logic [RAMP_WIDTH-1:0] RAMP_THRESHOLD_RESET = RAMP_WIDTH'(500);
   localparam logic [RAMP_WIDTH-1:0] RAMP_CEILING_RESET = RAMP_WIDTH'(10000);
   localparam logic [FREQ_WIDTH-1:0] CRITICAL_RESET = FREQ_WIDTH'(200);
   localparam logic [FREQ_WIDTH-1:0] ALERT_RESET = FREQ_WIDTH'(100);
   localparam logic [WARMUP_WIDTH-1:0] WARMUP_RESET = WARMUP_WIDTH'(10);

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RAMP_THRESHOLD = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RAMP_CEILING = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CRITICAL = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ALERT = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WARMUP = 3'd5;

   typedef enum logic [2:0] {
      ALERT_NONE      = 3'd0,
      ALERT_AMPLITUDE = 3'd1,
      ALERT_RAMP      = 3'd2,
      ALERT_CRITICAL  = 3'd3,
      ALERT_DEVIATION = 3'd4
   } alert_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_AVG,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic prep;
      logic div_step;
      logic average;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic good;
   } status_type;

endpackage

`default_nettype wire

FILE: design/grid_frequency_alert_classifier_top.sv
// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  one frequency measurement
// rsp       out        rsp_tvalid/rsp_tready  one classified result
// csr       in         csr_wr_en              register index and write data
//
// A good sample goes through capture, prep, the bit-serial divider for the ramp (one
// quotient bit a cycle), averaging and commit; a bad sample skips divider and averaging.
// One item is in work at a time; the input is taken again as soon as the
// result moves to the output register, which holds it while rsp_tready is low.
// Synchronous reset restores control, CSR, history and warmup state, not data registers.
`default_nettype none

`include "grid_frequency_alert_classifier_top_defines.svh"

module grid_frequency_alert_classifier_top
   import gfac_pkg::*;
#(
   parameter int TIME_WIDTH = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   // frequency_mhz, timestamp_ms
   input  wire logic [((FREQ_WIDTH+TIME_WIDTH+7)/8)*8-1:0] req_tdata,
   // signal_good
   input  wire logic [0:0]                 req_tuser,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   // deviation_mhz, delay_ms, ramp_mhz_s
   output logic [((FREQ_WIDTH+TIME_WIDTH+RAMP_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // measure_valid, has_alert, alert_kind
   output logic [4:0]                      rsp_tuser,
   input  wire logic                       csr_wr_en,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int RSP_DATA_WIDTH = ((FREQ_WIDTH + TIME_WIDTH + RAMP_WIDTH + 7) / 8) * 8;

   cmd_type cmd;
   status_type status;
   logic meas_valid;
   alert_kind_type kind;
   logic [FREQ_WIDTH-1:0] deviation;
   logic [TIME_WIDTH-1:0] delay;
   logic [RAMP_WIDTH-1:0] ramp;

   gfac_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   gfac_datapath #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .in_good           (req_tuser[0]),
      .in_freq           (req_tdata[FREQ_WIDTH-1:0]),
      .in_time           (req_tdata[FREQ_WIDTH+TIME_WIDTH-1:FREQ_WIDTH]),
      .out_measure_valid (meas_valid),
      .out_kind          (kind),
      .out_deviation     (deviation),
      .out_delay         (delay),
      .out_ramp          (ramp)
   );

   assign rsp_tdata = RSP_DATA_WIDTH'({ramp, delay, deviation});
   assign rsp_tuser = {kind, (kind != ALERT_NONE), meas_valid};

   `GFAC_ASSERT_IMPLY(a_commit_free, clock, reset, cmd.commit, !rsp_tvalid || rsp_tready, "result overwrote a pending item")
   `GFAC_ASSERT_NEXT(a_accept_prep, clock, reset, req_tvalid && req_tready, cmd.prep && !req_tready, "accepted item did not start")
   `GFAC_ASSERT_IMPLY(a_amp_zero, clock, reset, rsp_tvalid && kind == ALERT_AMPLITUDE, deviation == '0 && delay == '0 && ramp == '0, "amplitude result carries data")
   `GFAC_ASSERT_IMPLY(a_single_cmd, clock, reset, 1'b1, $onehot0(cmd), "more than one command at once")

endmodule

`default_nettype wire

FILE: design/gfac_ctrl.sv
`default_nettype none

module gfac_ctrl
   import gfac_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;
   logic [DIV_COUNT_WIDTH-1:0] count_ff, count_in;
   logic valid_ff, valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cmd = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            count_in = '0;
            // a bad sample needs no ramp
            state_in = status.good ? ST_DIV : ST_DONE;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            count_in = count_ff + 1'b1;
            if (count_ff == DIV_LAST) begin
               state_in = ST_AVG;
            end
         end
         ST_AVG: begin
            cmd.average = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!valid_ff || rsp_tready) begin
               cmd.commit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      valid_in = (valid_ff && !rsp_tready) || cmd.commit;
   end

   assign rsp_tvalid = valid_ff;

endmodule

`default_nettype wire

FILE: design/gfac_datapath.sv
`default_nettype none

module gfac_datapath
   import gfac_pkg::*;
#(
   parameter int TIME_WIDTH = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cmd_type                    cmd,
   output status_type                      status,
   input  wire logic                       csr_wr_en,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  wire logic                       in_good,
   input  wire logic [FREQ_WIDTH-1:0]      in_freq,
   input  wire logic [TIME_WIDTH-1:0]      in_time,
   output logic                            out_measure_valid,
   output alert_kind_type                  out_kind,
   output logic [FREQ_WIDTH-1:0]           out_deviation,
   output logic [TIME_WIDTH-1:0]           out_delay,
   output logic [RAMP_WIDTH-1:0]           out_ramp
);

   // configuration
   logic [FREQ_WIDTH-1:0] target_ff, critical_ff, alert_ff;
   logic [RAMP_WIDTH-1:0] ramp_thr_ff, ramp_ceil_ff;
   logic [WARMUP_WIDTH-1:0] warmup_reload_ff;

   // architectural state
   logic [WARMUP_WIDTH-1:0] warmup_ff;
   logic [TIME_WIDTH-1:0] prev_time_ff;
   logic [FREQ_WIDTH-1:0] prev_freq_ff;
   logic [RAMP_WIDTH-1:0] prev_ramp_ff;

   // working registers
   logic good_ff;
   logic [FREQ_WIDTH-1:0] freq_ff, dev_ff;
   logic [TIME_WIDTH-1:0] time_ff, delay_ff, rem_ff;
   logic delay_zero_ff;
   logic [NUM_WIDTH-1:0] num_ff;
   logic [RAMP_WIDTH-1:0] cur_ff, ramp_ff;

   // output register
   logic meas_valid_ff;
   alert_kind_type kind_ff;
   logic [FREQ_WIDTH-1:0] out_dev_ff;
   logic [TIME_WIDTH-1:0] out_delay_ff;
   logic [RAMP_WIDTH-1:0] out_ramp_ff;

   logic [FREQ_WIDTH-1:0] dev_in, freq_diff;
   logic [TIME_WIDTH-1:0] delay_in;
   logic [NUM_WIDTH-1:0] num_in;
   logic [TIME_WIDTH:0] rem_shift;
   logic rem_ge;
   logic [RAMP_WIDTH-1:0] cur_in;
   logic [RAMP_WIDTH:0] ramp_sum;
   alert_kind_type kind_in;

   always_comb begin
      dev_in = (freq_ff >= target_ff) ? freq_ff - target_ff : target_ff - freq_ff;
      freq_diff = (freq_ff >= prev_freq_ff) ? freq_ff - prev_freq_ff
                                            : prev_freq_ff - freq_ff;
      num_in = NUM_WIDTH'(freq_diff) * MS_PER_S;
      delay_in = time_ff - prev_time_ff;

      // one restoring divide step
      rem_shift = {rem_ff, num_ff[NUM_WIDTH-1]};
      rem_ge = rem_shift >= {1'b0, delay_ff};

      if (delay_zero_ff || (|num_ff[NUM_WIDTH-1:RAMP_WIDTH])) begin
         cur_in = RAMP_MAX;
      end else begin
         cur_in = num_ff[RAMP_WIDTH-1:0];
      end
      ramp_sum = {1'b0, cur_in} + {1'b0, prev_ramp_ff};

      priority if (!good_ff) begin
         kind_in = ALERT_AMPLITUDE;
      end else if (ramp_ff >= ramp_thr_ff && ramp_ff < ramp_ceil_ff) begin
         kind_in = ALERT_RAMP;
      end else if (dev_ff >= critical_ff) begin
         kind_in = ALERT_CRITICAL;
      end else if (dev_ff >= alert_ff) begin
         kind_in = ALERT_DEVIATION;
      end else begin
         kind_in = ALERT_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_RESET;
         ramp_thr_ff <= RAMP_THRESHOLD_RESET;
         ramp_ceil_ff <= RAMP_CEILING_RESET;
         critical_ff <= CRITICAL_RESET;
         alert_ff <= ALERT_RESET;
         warmup_reload_ff <= WARMUP_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TARGET:         target_ff <= csr_wdata[FREQ_WIDTH-1:0];
            CSR_RAMP_THRESHOLD: ramp_thr_ff <= csr_wdata;
            CSR_RAMP_CEILING:   ramp_ceil_ff <= csr_wdata;
            CSR_CRITICAL:       critical_ff <= csr_wdata[FREQ_WIDTH-1:0];
            CSR_ALERT:          alert_ff <= csr_wdata[FREQ_WIDTH-1:0];
            CSR_WARMUP:         warmup_reload_ff <= csr_wdata[WARMUP_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         warmup_ff <= WARMUP_RESET;
         prev_time_ff <= '0;
         prev_freq_ff <= '0;
         prev_ramp_ff <= '0;
      end else if (cmd.commit) begin
         if (!good_ff) begin
            warmup_ff <= warmup_reload_ff;
         end else begin
            if (warmup_ff != '0) begin
               warmup_ff <= warmup_ff - 1'b1;
            end
            prev_time_ff <= time_ff;
            prev_freq_ff <= freq_ff;
            prev_ramp_ff <= cur_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         good_ff <= in_good;
         freq_ff <= in_freq;
         time_ff <= in_time;
      end
      if (cmd.prep) begin
         dev_ff <= dev_in;
         delay_ff <= delay_in;
         delay_zero_ff <= (delay_in == '0);
         num_ff <= num_in;
         rem_ff <= '0;
      end
      if (cmd.div_step) begin
         num_ff <= {num_ff[NUM_WIDTH-2:0], rem_ge};
         rem_ff <= rem_ge ? TIME_WIDTH'(rem_shift - {1'b0, delay_ff})
                          : rem_shift[TIME_WIDTH-1:0];
      end
      if (cmd.average) begin
         cur_ff <= cur_in;
         ramp_ff <= ramp_sum[RAMP_WIDTH:1];
      end
      if (cmd.commit) begin
         meas_valid_ff <= (warmup_ff == '0);
         kind_ff <= kind_in;
         out_dev_ff <= good_ff ? dev_ff : '0;
         out_delay_ff <= good_ff ? delay_ff : '0;
         out_ramp_ff <= good_ff ? ramp_ff : '0;
      end
   end

   assign status.good = good_ff;
   assign out_measure_valid = meas_valid_ff;
   assign out_kind = kind_ff;
   assign out_deviation = out_dev_ff;
   assign out_delay = out_delay_ff;
   assign out_ramp = out_ramp_ff;

endmodule

`default_nettype wire
